FILE: src/tps_pkg.sv
package tps_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int NORM_WIDTH   = 16;
    localparam int OFFSET_WIDTH = 32;
    localparam int CFG_WIDTH    = 32;
    localparam int T_WIDTH      = 16;
    localparam int NUM_VERT     = 4;
    localparam int NUM_EDGE     = 6;
    localparam int NUM_SLOT     = 4;
    localparam int AXES         = 3;
    localparam int CNT_WIDTH    = 3;

    typedef enum logic [1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_PLANE_OFFSET
    } t_reg_idx;

    typedef logic [1:0] t_vidx;

    // edges in visiting order
    localparam t_vidx EDGE_FROM [NUM_EDGE] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_vidx EDGE_TO   [NUM_EDGE] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    typedef struct packed {
        logic  hit;
        t_vidx from;
        t_vidx to;
    } t_meta;

    // exact width of n.p - c
    function automatic int dist_width(input int cw);
        return ((cw + NORM_WIDTH + 2 > OFFSET_WIDTH) ? cw + NORM_WIDTH + 2 : OFFSET_WIDTH) + 1;
    endfunction

endpackage

FILE: src/tps_dist.sv
module tps_dist #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH,
    localparam int DW = tps_pkg::dist_width(COORD_WIDTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [tps_pkg::NORM_WIDTH-1:0]   i_nx,
    input  logic signed [tps_pkg::NORM_WIDTH-1:0]   i_ny,
    input  logic signed [tps_pkg::NORM_WIDTH-1:0]   i_nz,
    input  logic signed [tps_pkg::OFFSET_WIDTH-1:0] i_c,
    input  logic signed [COORD_WIDTH-1:0]       i_vert [tps_pkg::NUM_VERT][tps_pkg::AXES],
    output logic                                o_valid,
    output tps_pkg::t_meta                      o_meta [tps_pkg::NUM_SLOT],
    output logic        [DW-1:0]                o_ai   [tps_pkg::NUM_SLOT],
    output logic        [DW:0]                  o_den  [tps_pkg::NUM_SLOT],
    output logic signed [COORD_WIDTH-1:0]       o_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]       o_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic        [tps_pkg::CNT_WIDTH-1:0] o_cnt
);

    localparam int PW = COORD_WIDTH + tps_pkg::NORM_WIDTH;

    // stage 1: products
    logic                          r_v1;
    logic signed [PW-1:0]          r_prod  [tps_pkg::NUM_VERT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] r_vert1 [tps_pkg::NUM_VERT][tps_pkg::AXES];
    logic signed [tps_pkg::OFFSET_WIDTH-1:0] r_c1;
    // stage 2: distances
    logic                          r_v2;
    logic signed [DW-1:0]          r_d     [tps_pkg::NUM_VERT];
    logic signed [COORD_WIDTH-1:0] r_vert2 [tps_pkg::NUM_VERT][tps_pkg::AXES];
    logic signed [DW-1:0]          n_d     [tps_pkg::NUM_VERT];
    // stage 3: crossing edges packed into slots
    logic                          r_v3;
    tps_pkg::t_meta                r_meta [tps_pkg::NUM_SLOT];
    logic        [DW-1:0]          r_ai   [tps_pkg::NUM_SLOT];
    logic        [DW:0]            r_den  [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] r_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] r_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] r_cnt;
    tps_pkg::t_meta                n_meta [tps_pkg::NUM_SLOT];
    logic        [DW-1:0]          n_ai   [tps_pkg::NUM_SLOT];
    logic        [DW:0]            n_den  [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] n_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] n_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] n_cnt;

    logic signed [DW-1:0] da, db;
    logic        [DW-1:0] aa, ab;
    logic                 crosses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        for (int v = 0; v < tps_pkg::NUM_VERT; v++) begin
            n_d[v] = DW'(r_prod[v][0]) + DW'(r_prod[v][1]) + DW'(r_prod[v][2]) - DW'(r_c1);
        end
    end

    always_comb begin
        n_cnt = '0;
        da = '0;
        db = '0;
        aa = '0;
        ab = '0;
        crosses = 1'b0;
        for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
            n_meta[s] = '0;
            n_ai[s]   = '0;
            n_den[s]  = '0;
            for (int k = 0; k < tps_pkg::AXES; k++) begin
                n_pf[s][k] = '0;
                n_pt[s][k] = '0;
            end
        end
        for (int e = 0; e < tps_pkg::NUM_EDGE; e++) begin
            da = r_d[tps_pkg::EDGE_FROM[e]];
            db = r_d[tps_pkg::EDGE_TO[e]];
            aa = da[DW-1] ? DW'(-da) : DW'(da);
            ab = db[DW-1] ? DW'(-db) : DW'(db);
            // strict sign change; a vertex on the plane never counts
            crosses = (da[DW-1] && !db[DW-1] && (db != '0))
                   || (db[DW-1] && !da[DW-1] && (da != '0));
            if (crosses && (n_cnt < tps_pkg::CNT_WIDTH'(tps_pkg::NUM_SLOT))) begin
                n_meta[n_cnt[1:0]].hit  = 1'b1;
                n_meta[n_cnt[1:0]].from = tps_pkg::EDGE_FROM[e];
                n_meta[n_cnt[1:0]].to   = tps_pkg::EDGE_TO[e];
                n_ai[n_cnt[1:0]]        = aa;
                n_den[n_cnt[1:0]]       = (DW + 1)'(aa) + (DW + 1)'(ab);
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    n_pf[n_cnt[1:0]][k] = r_vert2[tps_pkg::EDGE_FROM[e]][k];
                    n_pt[n_cnt[1:0]][k] = r_vert2[tps_pkg::EDGE_TO[e]][k];
                end
                n_cnt = n_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_c;
            for (int v = 0; v < tps_pkg::NUM_VERT; v++) begin
                r_prod[v][0] <= i_nx * i_vert[v][0];
                r_prod[v][1] <= i_ny * i_vert[v][1];
                r_prod[v][2] <= i_nz * i_vert[v][2];
                r_d[v]       <= n_d[v];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_vert1[v][k] <= i_vert[v][k];
                    r_vert2[v][k] <= r_vert1[v][k];
                end
            end
            r_cnt <= n_cnt;
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_meta[s] <= n_meta[s];
                r_ai[s]   <= n_ai[s];
                r_den[s]  <= n_den[s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_pf[s][k] <= n_pf[s][k];
                    r_pt[s][k] <= n_pt[s][k];
                end
            end
        end
    end

    assign o_valid = r_v3;
    assign o_meta  = r_meta;
    assign o_ai    = r_ai;
    assign o_den   = r_den;
    assign o_pf    = r_pf;
    assign o_pt    = r_pt;
    assign o_cnt   = r_cnt;

endmodule

FILE: src/tps_div.sv
module tps_div #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH,
    localparam int DW = tps_pkg::dist_width(COORD_WIDTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tps_pkg::t_meta                      i_meta [tps_pkg::NUM_SLOT],
    input  logic        [DW-1:0]                i_ai   [tps_pkg::NUM_SLOT],
    input  logic        [DW:0]                  i_den  [tps_pkg::NUM_SLOT],
    input  logic signed [COORD_WIDTH-1:0]       i_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0]       i_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    input  logic        [tps_pkg::CNT_WIDTH-1:0] i_cnt,
    output logic                                o_valid,
    output tps_pkg::t_meta                      o_meta [tps_pkg::NUM_SLOT],
    output logic        [tps_pkg::T_WIDTH-1:0]  o_t    [tps_pkg::NUM_SLOT],
    output logic signed [COORD_WIDTH-1:0]       o_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]       o_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic        [tps_pkg::CNT_WIDTH-1:0] o_cnt
);

    // restoring divider, one quotient bit per stage
    localparam int QW = tps_pkg::T_WIDTH;
    localparam int NW = DW + 1;
    localparam int RW = DW + 2;

    logic                          r_v    [QW];
    logic        [RW-1:0]          r_rem  [QW][tps_pkg::NUM_SLOT];
    logic        [NW-1:0]          r_den  [QW][tps_pkg::NUM_SLOT];
    logic        [QW-1:0]          r_q    [QW][tps_pkg::NUM_SLOT];
    tps_pkg::t_meta                r_meta [QW][tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] r_pf   [QW][tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] r_pt   [QW][tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] r_cnt [QW];

    logic        [RW-1:0]          n_rem  [QW][tps_pkg::NUM_SLOT];
    logic        [QW-1:0]          n_q    [QW][tps_pkg::NUM_SLOT];

    logic [RW-1:0] rem_in, shl;
    logic [NW-1:0] den_in;
    logic [QW-1:0] q_in;

    always_comb begin
        rem_in = '0;
        shl    = '0;
        den_in = '0;
        q_in   = '0;
        for (int j = 0; j < QW; j++) begin
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                if (j == 0) begin
                    rem_in = RW'(i_ai[s]);
                    den_in = i_den[s];
                    q_in   = '0;
                end else begin
                    rem_in = r_rem[j-1][s];
                    den_in = r_den[j-1][s];
                    q_in   = r_q[j-1][s];
                end
                shl = {rem_in[RW-2:0], 1'b0};
                if (shl >= RW'(den_in)) begin
                    n_rem[j][s] = shl - RW'(den_in);
                    n_q[j][s]   = {q_in[QW-2:0], 1'b1};
                end else begin
                    n_rem[j][s] = shl;
                    n_q[j][s]   = {q_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QW; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < QW; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt[0] <= i_cnt;
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_meta[0][s] <= i_meta[s];
                r_den[0][s]  <= i_den[s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_pf[0][s][k] <= i_pf[s][k];
                    r_pt[0][s][k] <= i_pt[s][k];
                end
            end
            for (int j = 1; j < QW; j++) begin
                r_cnt[j] <= r_cnt[j-1];
                for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                    r_meta[j][s] <= r_meta[j-1][s];
                    r_den[j][s]  <= r_den[j-1][s];
                    for (int k = 0; k < tps_pkg::AXES; k++) begin
                        r_pf[j][s][k] <= r_pf[j-1][s][k];
                        r_pt[j][s][k] <= r_pt[j-1][s][k];
                    end
                end
            end
            for (int j = 0; j < QW; j++) begin
                for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                    r_rem[j][s] <= n_rem[j][s];
                    r_q[j][s]   <= n_q[j][s];
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_meta  = r_meta[QW-1];
    assign o_t     = r_q[QW-1];
    assign o_pf    = r_pf[QW-1];
    assign o_pt    = r_pt[QW-1];
    assign o_cnt   = r_cnt[QW-1];

endmodule

FILE: src/tps_interp.sv
module tps_interp #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tps_pkg::t_meta                      i_meta [tps_pkg::NUM_SLOT],
    input  logic        [tps_pkg::T_WIDTH-1:0]  i_t    [tps_pkg::NUM_SLOT],
    input  logic signed [COORD_WIDTH-1:0]       i_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0]       i_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    input  logic        [tps_pkg::CNT_WIDTH-1:0] i_cnt,
    output logic                                o_valid,
    output tps_pkg::t_meta                      o_meta [tps_pkg::NUM_SLOT],
    output logic        [tps_pkg::T_WIDTH-1:0]  o_t    [tps_pkg::NUM_SLOT],
    output logic signed [COORD_WIDTH-1:0]       o_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic        [tps_pkg::CNT_WIDTH-1:0] o_cnt
);

    localparam int PRW   = COORD_WIDTH + tps_pkg::T_WIDTH + 2;
    localparam int ROUND = 1 << (tps_pkg::T_WIDTH - 1);

    logic                          r_v1, r_v2;
    logic signed [PRW-1:0]         r_prod [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] r_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    tps_pkg::t_meta                r_meta1 [tps_pkg::NUM_SLOT];
    tps_pkg::t_meta                r_meta2 [tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] r_t1 [tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] r_t2 [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] r_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] r_cnt1, r_cnt2;

    logic signed [COORD_WIDTH:0]   diff   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [PRW-1:0]         n_prod [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [PRW-1:0]         rnd    [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] n_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES];

    always_comb begin
        for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
            for (int k = 0; k < tps_pkg::AXES; k++) begin
                diff[s][k]   = (COORD_WIDTH + 1)'(i_pt[s][k]) - (COORD_WIDTH + 1)'(i_pf[s][k]);
                n_prod[s][k] = $signed({1'b0, i_t[s]}) * diff[s][k];
                // round half up, then floor shift
                rnd[s][k]    = r_prod[s][k] + PRW'(ROUND);
                n_pos[s][k]  = COORD_WIDTH'(PRW'(r_pf[s][k])
                             + (rnd[s][k] >>> tps_pkg::T_WIDTH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt1 <= i_cnt;
            r_cnt2 <= r_cnt1;
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_meta1[s] <= i_meta[s];
                r_meta2[s] <= r_meta1[s];
                r_t1[s]    <= i_t[s];
                r_t2[s]    <= r_t1[s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_prod[s][k] <= n_prod[s][k];
                    r_pf[s][k]   <= i_pf[s][k];
                    r_pos[s][k]  <= n_pos[s][k];
                end
            end
        end
    end

    assign o_valid = r_v2;
    assign o_meta  = r_meta2;
    assign o_t     = r_t2;
    assign o_pos   = r_pos;
    assign o_cnt   = r_cnt2;

endmodule

FILE: src/tps_quad.sv
module tps_quad #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tps_pkg::t_meta                      i_meta [tps_pkg::NUM_SLOT],
    input  logic        [tps_pkg::T_WIDTH-1:0]  i_t    [tps_pkg::NUM_SLOT],
    input  logic signed [COORD_WIDTH-1:0]       i_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    input  logic        [tps_pkg::CNT_WIDTH-1:0] i_cnt,
    output logic                                o_valid,
    output tps_pkg::t_meta                      o_meta [tps_pkg::NUM_SLOT],
    output logic        [tps_pkg::T_WIDTH-1:0]  o_t    [tps_pkg::NUM_SLOT],
    output logic signed [COORD_WIDTH-1:0]       o_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES],
    output logic        [tps_pkg::CNT_WIDTH-1:0] o_cnt
);

    // sign of ((q1-q0)x(q2-q0)) . ((q2-q0)x(q3-q0)), exact
    localparam int QS  = 5;
    localparam int DFW = COORD_WIDTH + 1;
    localparam int PPW = 2 * DFW;
    localparam int CW  = PPW + 1;
    localparam int H   = (CW + 1) / 2;
    localparam int HI  = CW - H;
    localparam int TW  = 2 * CW;
    localparam int SW  = TW + 2;

    logic                          r_v    [QS];
    tps_pkg::t_meta                r_meta [QS][tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] r_t [QS][tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] r_pos  [QS][tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] r_cnt [QS];

    logic signed [PPW-1:0]  r_xa [tps_pkg::AXES], r_xb [tps_pkg::AXES];
    logic signed [PPW-1:0]  r_ya [tps_pkg::AXES], r_yb [tps_pkg::AXES];
    logic signed [CW-1:0]   r_ca [tps_pkg::AXES], r_cb [tps_pkg::AXES];
    logic signed [2*HI-1:0] r_hh [tps_pkg::AXES];
    logic signed [HI+H:0]   r_hl [tps_pkg::AXES], r_lh [tps_pkg::AXES];
    logic        [2*H-1:0]  r_ll [tps_pkg::AXES];
    logic signed [TW-1:0]   r_term [tps_pkg::AXES];

    logic signed [DFW-1:0]  u [tps_pkg::AXES], v [tps_pkg::AXES], w [tps_pkg::AXES];
    logic signed [TW-1:0]   n_term [tps_pkg::AXES];
    logic signed [SW-1:0]   dot;
    logic                   fold;

    always_comb begin
        for (int k = 0; k < tps_pkg::AXES; k++) begin
            u[k] = DFW'(i_pos[1][k]) - DFW'(i_pos[0][k]);
            v[k] = DFW'(i_pos[2][k]) - DFW'(i_pos[0][k]);
            w[k] = DFW'(i_pos[3][k]) - DFW'(i_pos[0][k]);
            n_term[k] = (TW'(r_hh[k]) <<< (2 * H))
                      + ((TW'(r_hl[k]) + TW'(r_lh[k])) <<< H)
                      + TW'($signed({1'b0, r_ll[k]}));
        end
        dot  = SW'(r_term[0]) + SW'(r_term[1]) + SW'(r_term[2]);
        fold = dot[SW-1] && (r_cnt[QS-2] == tps_pkg::CNT_WIDTH'(tps_pkg::NUM_SLOT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QS; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < QS; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < tps_pkg::AXES; k++) begin
                r_xa[k] <= u[(k + 1) % 3] * v[(k + 2) % 3];
                r_xb[k] <= u[(k + 2) % 3] * v[(k + 1) % 3];
                r_ya[k] <= v[(k + 1) % 3] * w[(k + 2) % 3];
                r_yb[k] <= v[(k + 2) % 3] * w[(k + 1) % 3];
                r_ca[k] <= CW'(r_xa[k]) - CW'(r_xb[k]);
                r_cb[k] <= CW'(r_ya[k]) - CW'(r_yb[k]);
                // split into high signed and low unsigned halves
                r_hh[k] <= $signed(r_ca[k][CW-1:H]) * $signed(r_cb[k][CW-1:H]);
                r_hl[k] <= $signed(r_ca[k][CW-1:H]) * $signed({1'b0, r_cb[k][H-1:0]});
                r_lh[k] <= $signed({1'b0, r_ca[k][H-1:0]}) * $signed(r_cb[k][CW-1:H]);
                r_ll[k] <= r_ca[k][H-1:0] * r_cb[k][H-1:0];
                r_term[k] <= n_term[k];
            end
            r_cnt[0] <= i_cnt;
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_meta[0][s] <= i_meta[s];
                r_t[0][s]    <= i_t[s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_pos[0][s][k] <= i_pos[s][k];
                end
            end
            for (int j = 1; j < QS - 1; j++) begin
                r_cnt[j] <= r_cnt[j-1];
                for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                    r_meta[j][s] <= r_meta[j-1][s];
                    r_t[j][s]    <= r_t[j-1][s];
                    for (int k = 0; k < tps_pkg::AXES; k++) begin
                        r_pos[j][s][k] <= r_pos[j-1][s][k];
                    end
                end
            end
            // last stage swaps points 2 and 3 on a folded quad
            r_cnt[QS-1] <= r_cnt[QS-2];
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_meta[QS-1][s] <= r_meta[QS-2][(fold && s == 2) ? 3 : (fold && s == 3) ? 2 : s];
                r_t[QS-1][s]    <= r_t[QS-2][(fold && s == 2) ? 3 : (fold && s == 3) ? 2 : s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_pos[QS-1][s][k] <=
                        r_pos[QS-2][(fold && s == 2) ? 3 : (fold && s == 3) ? 2 : s][k];
                end
            end
        end
    end

    assign o_valid = r_v[QS-1];
    assign o_meta  = r_meta[QS-1];
    assign o_t     = r_t[QS-1];
    assign o_pos   = r_pos[QS-1];
    assign o_cnt   = r_cnt[QS-1];

endmodule

FILE: src/tet_plane_slice.sv
// Pipeline: an accepted input word passes through 3 distance/select, 16 divider,
//   2 interpolation and 5 quad-test stages, then 1 output register.
// Throughput: one input word per cycle into the pipeline while o_ready is high; o_ready
//   drops while the last stage is full and the one-word output port still sends older points.
// Reset: synchronous active-low; clears all valid bits and loads normal (0, 1.0, 0), offset 0.
module tet_plane_slice #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [tps_pkg::CFG_WIDTH-1:0]          i_cfg_data,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [COORD_WIDTH-1:0]          i_v0_x,
    input  logic signed [COORD_WIDTH-1:0]          i_v0_y,
    input  logic signed [COORD_WIDTH-1:0]          i_v0_z,
    input  logic signed [COORD_WIDTH-1:0]          i_v1_x,
    input  logic signed [COORD_WIDTH-1:0]          i_v1_y,
    input  logic signed [COORD_WIDTH-1:0]          i_v1_z,
    input  logic signed [COORD_WIDTH-1:0]          i_v2_x,
    input  logic signed [COORD_WIDTH-1:0]          i_v2_y,
    input  logic signed [COORD_WIDTH-1:0]          i_v2_z,
    input  logic signed [COORD_WIDTH-1:0]          i_v3_x,
    input  logic signed [COORD_WIDTH-1:0]          i_v3_y,
    input  logic signed [COORD_WIDTH-1:0]          i_v3_z,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [COORD_WIDTH-1:0]          o_point_x,
    output logic signed [COORD_WIDTH-1:0]          o_point_y,
    output logic signed [COORD_WIDTH-1:0]          o_point_z,
    output logic [1:0]                             o_edge_from,
    output logic [1:0]                             o_edge_to,
    output logic [tps_pkg::T_WIDTH-1:0]            o_crossing_param,
    output logic                                   o_last_point
);

    localparam int DW = tps_pkg::dist_width(COORD_WIDTH);

    // plane registers
    logic signed [tps_pkg::NORM_WIDTH-1:0]   r_nx, r_ny, r_nz;
    logic signed [tps_pkg::OFFSET_WIDTH-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= tps_pkg::NORM_WIDTH'(1 << (tps_pkg::NORM_WIDTH - 2));
            r_nz <= '0;
            r_c  <= '0;
        end else if (i_cfg_we) begin
            case (tps_pkg::t_reg_idx'(i_cfg_idx))
                tps_pkg::REG_NORMAL_X:     r_nx <= i_cfg_data[tps_pkg::NORM_WIDTH-1:0];
                tps_pkg::REG_NORMAL_Y:     r_ny <= i_cfg_data[tps_pkg::NORM_WIDTH-1:0];
                tps_pkg::REG_NORMAL_Z:     r_nz <= i_cfg_data[tps_pkg::NORM_WIDTH-1:0];
                tps_pkg::REG_PLANE_OFFSET: r_c  <= i_cfg_data[tps_pkg::OFFSET_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // global pipeline advance: moves whenever the last stage is empty or the
    // output register takes its word
    logic en;
    logic ser_free;

    logic signed [COORD_WIDTH-1:0] vert [tps_pkg::NUM_VERT][tps_pkg::AXES];

    assign vert[0][0] = i_v0_x;
    assign vert[0][1] = i_v0_y;
    assign vert[0][2] = i_v0_z;
    assign vert[1][0] = i_v1_x;
    assign vert[1][1] = i_v1_y;
    assign vert[1][2] = i_v1_z;
    assign vert[2][0] = i_v2_x;
    assign vert[2][1] = i_v2_y;
    assign vert[2][2] = i_v2_z;
    assign vert[3][0] = i_v3_x;
    assign vert[3][1] = i_v3_y;
    assign vert[3][2] = i_v3_z;

    // distances and slot packing
    logic                          s_valid;
    tps_pkg::t_meta                s_meta [tps_pkg::NUM_SLOT];
    logic        [DW-1:0]          s_ai   [tps_pkg::NUM_SLOT];
    logic        [DW:0]            s_den  [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] s_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] s_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] s_cnt;

    tps_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .i_nz    (r_nz),
        .i_c     (r_c),
        .i_vert  (vert),
        .o_valid (s_valid),
        .o_meta  (s_meta),
        .o_ai    (s_ai),
        .o_den   (s_den),
        .o_pf    (s_pf),
        .o_pt    (s_pt),
        .o_cnt   (s_cnt)
    );

    // crossing parameter t = floor(|d_from| * 2^16 / (|d_from| + |d_to|))
    logic                          d_valid;
    tps_pkg::t_meta                d_meta [tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] d_t [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] d_pf   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] d_pt   [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] d_cnt;

    tps_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_meta  (s_meta),
        .i_ai    (s_ai),
        .i_den   (s_den),
        .i_pf    (s_pf),
        .i_pt    (s_pt),
        .i_cnt   (s_cnt),
        .o_valid (d_valid),
        .o_meta  (d_meta),
        .o_t     (d_t),
        .o_pf    (d_pf),
        .o_pt    (d_pt),
        .o_cnt   (d_cnt)
    );

    // point positions
    logic                          p_valid;
    tps_pkg::t_meta                p_meta [tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] p_t [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] p_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] p_cnt;

    tps_interp #(.COORD_WIDTH(COORD_WIDTH)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_meta  (d_meta),
        .i_t     (d_t),
        .i_pf    (d_pf),
        .i_pt    (d_pt),
        .i_cnt   (d_cnt),
        .o_valid (p_valid),
        .o_meta  (p_meta),
        .o_t     (p_t),
        .o_pos   (p_pos),
        .o_cnt   (p_cnt)
    );

    // quad orientation fix
    logic                          q_valid;
    tps_pkg::t_meta                q_meta [tps_pkg::NUM_SLOT];
    logic        [tps_pkg::T_WIDTH-1:0] q_t [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] q_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic        [tps_pkg::CNT_WIDTH-1:0] q_cnt;

    tps_quad #(.COORD_WIDTH(COORD_WIDTH)) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_meta  (p_meta),
        .i_t     (p_t),
        .i_pos   (p_pos),
        .i_cnt   (p_cnt),
        .o_valid (q_valid),
        .o_meta  (q_meta),
        .o_t     (q_t),
        .o_pos   (q_pos),
        .o_cnt   (q_cnt)
    );

    // output register: holds one tetrahedron and sends its points one word
    // per cycle while i_ready is high; a tetrahedron with no crossing is dropped here
    logic                          r_ser_valid;
    logic [1:0]                    r_ser_idx;
    logic [tps_pkg::CNT_WIDTH-1:0] r_ser_cnt;
    tps_pkg::t_meta                r_ser_meta [tps_pkg::NUM_SLOT];
    logic [tps_pkg::T_WIDTH-1:0]   r_ser_t    [tps_pkg::NUM_SLOT];
    logic signed [COORD_WIDTH-1:0] r_ser_pos  [tps_pkg::NUM_SLOT][tps_pkg::AXES];
    logic                          ser_last;

    assign ser_last = (tps_pkg::CNT_WIDTH'({1'b0, r_ser_idx}) + 1'b1) == r_ser_cnt;
    assign ser_free = !r_ser_valid || (i_ready && ser_last);
    assign en       = !q_valid || ser_free;
    assign o_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_ser_idx   <= '0;
        end else if (ser_free) begin
            r_ser_valid <= q_valid && (q_cnt != '0);
            r_ser_idx   <= '0;
        end else if (i_ready) begin
            r_ser_idx   <= r_ser_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free) begin
            r_ser_cnt <= q_cnt;
            for (int s = 0; s < tps_pkg::NUM_SLOT; s++) begin
                r_ser_meta[s] <= q_meta[s];
                r_ser_t[s]    <= q_t[s];
                for (int k = 0; k < tps_pkg::AXES; k++) begin
                    r_ser_pos[s][k] <= q_pos[s][k];
                end
            end
        end
    end

    assign o_valid          = r_ser_valid;
    assign o_point_x        = r_ser_pos[r_ser_idx][0];
    assign o_point_y        = r_ser_pos[r_ser_idx][1];
    assign o_point_z        = r_ser_pos[r_ser_idx][2];
    assign o_edge_from      = r_ser_meta[r_ser_idx].from;
    assign o_edge_to        = r_ser_meta[r_ser_idx].to;
    assign o_crossing_param = r_ser_t[r_ser_idx];
    assign o_last_point     = ser_last;

    // checks
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid |-> (tps_pkg::CNT_WIDTH'({1'b0, r_ser_idx}) < r_ser_cnt))
        else $error("output index past point count");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_valid |-> (r_ser_cnt != '0
                         && r_ser_cnt <= tps_pkg::CNT_WIDTH'(tps_pkg::NUM_SLOT)))
        else $error("held tetrahedron has bad point count");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_ser_valid && q_valid))
        else $error("pipeline stalled without a blocked output");

    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_edge_from < o_edge_to))
        else $error("edge vertices out of order");

endmodule

FILE: bench/tps_checker.sv
`timescale 1ns / 1ps

module tps_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  tps_pkg::t_reg_idx    i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [12*16-1:0]     i_verts,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [15:0]          i_point_x,
    input  logic [15:0]          i_point_y,
    input  logic [15:0]          i_point_z,
    input  logic [1:0]           i_edge_from,
    input  logic [1:0]           i_edge_to,
    input  logic [15:0]          i_crossing_param,
    input  logic                 i_last_point,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic [15:0] x, y, z;
        logic [1:0]  from, to;
        logic [15:0] t;
        logic        last;
    } t_slice_pt;

    t_slice_pt slice_pts_q[$];
    longint nrm_x, nrm_y, nrm_z, offset;

    assign o_pending = slice_pts_q.size();

    task automatic slice_tet(input logic [12*16-1:0] verts);
        longint p[4][3];
        longint d[4];
        longint pos[4][3];
        longint tmp[3];
        logic [1:0] pfrom[4], pto[4];
        longint t16[4];
        longint u[3], v[3], w[3], ca[3], cb[3];
        logic signed [127:0] a, b, dot;
        longint unsigned ai, den;
        int cnt;
        t_slice_pt pt;
        cnt = 0;
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++)
                p[i][k] = $signed(verts[(i*3+k)*16 +: 16]);
            d[i] = nrm_x * p[i][0] + nrm_y * p[i][1] + nrm_z * p[i][2] - offset;
        end
        // edges in order (0,1),(0,2),(0,3),(1,2),(1,3),(2,3); on-plane vertices never cross
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (((d[i] < 0 && d[j] > 0) || (d[i] > 0 && d[j] < 0)) && cnt < 4) begin
                    ai  = (d[i] < 0) ? -d[i] : d[i];
                    den = ai + ((d[j] < 0) ? -d[j] : d[j]);
                    t16[cnt] = (ai << 16) / den;
                    for (int k = 0; k < 3; k++)
                        pos[cnt][k] = p[i][k]
                                    + ((t16[cnt] * (p[j][k] - p[i][k]) + 32768) >>> 16);
                    pfrom[cnt] = i[1:0];
                    pto[cnt]   = j[1:0];
                    cnt++;
                end
            end
        end
        if (cnt == 4) begin
            for (int k = 0; k < 3; k++) begin
                u[k] = pos[1][k] - pos[0][k];
                v[k] = pos[2][k] - pos[0][k];
                w[k] = pos[3][k] - pos[0][k];
            end
            dot = 0;
            for (int k = 0; k < 3; k++) begin
                ca[k] = u[(k+1)%3] * v[(k+2)%3] - u[(k+2)%3] * v[(k+1)%3];
                cb[k] = v[(k+1)%3] * w[(k+2)%3] - v[(k+2)%3] * w[(k+1)%3];
            end
            for (int k = 0; k < 3; k++) begin
                a = ca[k];
                b = cb[k];
                dot += a * b;
            end
            // folded quad: swap the last two corners
            if (dot < 0) begin
                tmp    = pos[2];
                pos[2] = pos[3];
                pos[3] = tmp;
                {pfrom[2], pfrom[3]} = {pfrom[3], pfrom[2]};
                {pto[2], pto[3]}     = {pto[3], pto[2]};
                {t16[2], t16[3]}     = {t16[3], t16[2]};
            end
        end
        for (int i = 0; i < cnt; i++) begin
            pt.x    = pos[i][0][15:0];
            pt.y    = pos[i][1][15:0];
            pt.z    = pos[i][2][15:0];
            pt.from = pfrom[i];
            pt.to   = pto[i];
            pt.t    = t16[i][15:0];
            pt.last = (i == cnt - 1);
            slice_pts_q = {slice_pts_q, pt};
        end
    endtask

    task automatic check_word();
        t_slice_pt e;
        if (slice_pts_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("unexpected result word: x=%h y=%h z=%h", i_point_x, i_point_y,
                         i_point_z);
            return;
        end
        e = slice_pts_q.pop_front();
        if (e.x !== i_point_x || e.y !== i_point_y || e.z !== i_point_z
                || e.from !== i_edge_from || e.to !== i_edge_to
                || e.t !== i_crossing_param || e.last !== i_last_point) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display({"mismatch exp x=%h y=%h z=%h e=%0d-%0d t=%h l=%b",
                          " | got x=%h y=%h z=%h e=%0d-%0d t=%h l=%b"},
                         e.x, e.y, e.z, e.from, e.to, e.t, e.last,
                         i_point_x, i_point_y, i_point_z, i_edge_from, i_edge_to,
                         i_crossing_param, i_last_point);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nrm_x  = 0;
            nrm_y  = 16384;
            nrm_z  = 0;
            offset = 0;
            o_fail_count = 0;
            slice_pts_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                slice_tet(i_verts);
            if (i_out_valid && i_out_ready)
                check_word();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tps_pkg::REG_NORMAL_X:     nrm_x  = $signed(i_cfg_data[15:0]);
                    tps_pkg::REG_NORMAL_Y:     nrm_y  = $signed(i_cfg_data[15:0]);
                    tps_pkg::REG_NORMAL_Z:     nrm_z  = $signed(i_cfg_data[15:0]);
                    tps_pkg::REG_PLANE_OFFSET: offset = $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE = 40;      // longer than the pipeline latency
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    tps_pkg::t_reg_idx cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid, in_ready;
    logic [15:0] verts [12];
    logic        out_valid, out_ready;
    logic [15:0] pt_x, pt_y, pt_z, t_param;
    logic [1:0]  e_from, e_to;
    logic        last_pt;
    logic [12*16-1:0] vert_bus;
    int          fail_count, pending;
    bit          no_idle;    // quiet stretch: neither side stalls
    int          quiet_cycles;

    always_comb
        for (int i = 0; i < 12; i++)
            vert_bus[i*16 +: 16] = verts[i];

    tet_plane_slice dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_v0_x(verts[0]), .i_v0_y(verts[1]), .i_v0_z(verts[2]),
        .i_v1_x(verts[3]), .i_v1_y(verts[4]), .i_v1_z(verts[5]),
        .i_v2_x(verts[6]), .i_v2_y(verts[7]), .i_v2_z(verts[8]),
        .i_v3_x(verts[9]), .i_v3_y(verts[10]), .i_v3_z(verts[11]),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_point_x(pt_x), .o_point_y(pt_y), .o_point_z(pt_z),
        .o_edge_from(e_from), .o_edge_to(e_to),
        .o_crossing_param(t_param), .o_last_point(last_pt)
    );

    tps_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_verts(vert_bus),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .i_edge_from(e_from), .i_edge_to(e_to),
        .i_crossing_param(t_param), .i_last_point(last_pt),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side backpressure, ~15% stall except in quiet stretch
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 15);

    // watchdog: cycles with no word moving on either channel and no config write
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** tet_plane_slice: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input tps_pkg::t_reg_idx idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // plane = n.p - c; drain pipeline before touching registers
    task automatic set_plane(input logic [15:0] nx, ny, nz, input logic [31:0] c);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_write(tps_pkg::REG_NORMAL_X, {16'h0, nx});
        cfg_write(tps_pkg::REG_NORMAL_Y, {16'h0, ny});
        cfg_write(tps_pkg::REG_NORMAL_Z, {16'h0, nz});
        cfg_write(tps_pkg::REG_PLANE_OFFSET, c);
    endtask

    // drive one word at the falling edge, hold until accepted
    task automatic send_tet(input logic [15:0] v [12]);
        if (!no_idle && $urandom_range(99) < 15)
            repeat ($urandom_range(1, 6)) @(negedge clk);
        verts    = v;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_coords(input int c [12]);
        logic [15:0] v [12];
        for (int i = 0; i < 12; i++)
            v[i] = c[i][15:0];
        send_tet(v);
    endtask

    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8191)) - 4096);
            default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    task automatic random_tets(input int count);
        logic [15:0] v [12];
        int mode, r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            mode = (r < 55) ? 0 : 1;
            for (int i = 0; i < 12; i++)
                v[i] = ($urandom_range(99) < 8) ? rand_coord(2) : rand_coord(mode);
            send_tet(v);
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = tps_pkg::REG_NORMAL_X;
        cfg_data = '0;
        in_valid = 1'b0;
        no_idle  = 1'b0;
        for (int i = 0; i < 12; i++) verts[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset plane y = 0; coords as (x,y,z) per vertex
        send_coords('{100, 200, 0, -50, 300, 7, 9, 10, 11, 40, 4096, -3});       // no crossing
        send_coords('{0, -4096, 0, 4096, 4096, 0, 0, 4096, 4096, -4096, 4096, 0}); // triangle
        send_coords('{0, -4096, 0, 4096, -4096, 0, 0, 4096, 4096, -4096, 4096, 0}); // quad
        send_coords('{0, -4096, 0, 0, 4096, 4096, 4096, -4096, 0, -4096, 4096, 0}); // quad, other order
        send_coords('{0, -4096, 4096, 4096, 4096, 0, 0, 4096, -4096, 4096, -4096, 0});
        send_coords('{0, 0, 0, 4096, 4096, 0, 0, -4096, 4096, -4096, 4096, 0});   // vertex on plane
        send_coords('{0, 0, 0, 4096, 0, 0, 0, 0, 4096, 5, 0, 5});                 // all on plane
        send_coords('{5, 5, 5, 5, -5, 5, 5, 5, 5, 5, -5, 5});                     // coincident points
        send_coords('{-32768, -32768, -32768, 32767, 32767, 32767,
                      -32768, 32767, -32768, 32767, -32768, 32767});              // extremes
        send_coords('{32767, -1, 32767, -32768, 1, -32768, 0, -32768, 0, 1, 32767, -1});
        send_coords('{0, -1, 0, 0, 1, 0, 0, -32768, 0, 0, 32767, 0});             // thin crossings
        send_coords('{1, -4096, 2, 3, -4096, 4, 5, 4096, 6, 7, -4096, 8});

        random_tets(50);

        // pure x normal, zero offset, no idling at all
        set_plane(16'h4000, 16'h0000, 16'h0000, 32'h0);
        no_idle = 1'b1;
        random_tets(50);
        no_idle = 1'b0;

        // negative x and z extremes, positive y extreme, with max offset
        set_plane(16'h8000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF);
        random_tets(45);

        // positive extremes with min offset
        set_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000);
        random_tets(45);

        // random tilted plane, moderate offset
        set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                  32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
        random_tets(55);

        // degenerate zero normal: every distance is -c, never a crossing
        set_plane(16'h0000, 16'h0000, 16'h0000, 32'($urandom));
        random_tets(10);

        set_plane(16'h2D41, 16'hD2BF, 16'h1000, 32'h0100_0000);
        random_tets(50);

        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** tet_plane_slice: PASSED **");
        else
            $display("** tet_plane_slice: FAILED **");
        $finish;
    end

endmodule

FILE: tet_plane_slice.f
src/tps_pkg.sv
src/tps_dist.sv
src/tps_div.sv
src/tps_interp.sv
src/tps_quad.sv
src/tet_plane_slice.sv
bench/tps_checker.sv
bench/tb_top.sv
